FILE: hw/rtl/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  localparam int COEF_W        = 16;
  localparam int ROOT_W        = 40;
  localparam int IMAG_W        = 39;
  localparam int DEF_FRAC_BITS = 16;
  // |b*b - 4ac| stays below 2^33
  localparam int RAD_W         = 34;
  localparam int SQRT_W        = 17;
  // magnitude of -b +/- s and of 2|a|
  localparam int MAG_W         = 17;
  localparam int DIVR_W        = 17;
  localparam int LANES         = 3;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_REPEATED = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_DEGEN    = 2'd3
  } root_kind_t;

  typedef struct packed {
    root_kind_t               kind;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } sqrt_side_t;

  typedef struct packed {
    root_kind_t kind;
    logic       neg_one;
    logic       neg_two;
  } div_side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/qrs_disc.sv
`default_nettype none
module qrs_disc (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_vld,
  input  wire  signed [qrs_pkg::COEF_W-1:0] a,
  input  wire  signed [qrs_pkg::COEF_W-1:0] b,
  input  wire  signed [qrs_pkg::COEF_W-1:0] c,
  output logic                            out_vld,
  output logic [qrs_pkg::RAD_W-1:0]       rad,
  output qrs_pkg::sqrt_side_t             side
);
  import qrs_pkg::*;

  logic                      vld1_r;
  logic signed [2*COEF_W-1:0] bb_r, ac_r;
  logic signed [COEF_W-1:0]  a1_r, b1_r;
  logic signed [RAD_W-1:0]   d_nxt;
  root_kind_t                kind_nxt;
  logic                      vld2_r;
  logic [RAD_W-1:0]          rad_r;
  sqrt_side_t                side_r;

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    bb_r <= (2*COEF_W)'(b) * (2*COEF_W)'(b);
    ac_r <= (2*COEF_W)'(a) * (2*COEF_W)'(c);
    a1_r <= a;
    b1_r <= b;
  end

  // discriminant and root classification
  always_comb begin
    d_nxt = RAD_W'(bb_r) - (RAD_W'(ac_r) <<< 2);
    if (a1_r == '0) begin
      kind_nxt = KIND_DEGEN;
    end else if (d_nxt > 0) begin
      kind_nxt = KIND_TWO_REAL;
    end else if (d_nxt == '0) begin
      kind_nxt = KIND_REPEATED;
    end else begin
      kind_nxt = KIND_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    rad_r       <= d_nxt[RAD_W-1] ? RAD_W'(-d_nxt) : RAD_W'(d_nxt);
    side_r.kind <= kind_nxt;
    side_r.a    <= a1_r;
    side_r.b    <= b1_r;
  end

  assign out_vld = vld2_r;
  assign rad     = rad_r;
  assign side    = side_r;

endmodule
`default_nettype wire

FILE: hw/rtl/qrs_sqrt.sv
`default_nettype none
module qrs_sqrt (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_vld,
  input  wire [qrs_pkg::RAD_W-1:0]   rad,
  input  qrs_pkg::sqrt_side_t        in_side,
  output logic                       out_vld,
  output logic [qrs_pkg::SQRT_W-1:0] root,
  output qrs_pkg::sqrt_side_t        out_side
);
  import qrs_pkg::*;

  localparam int REM_W = SQRT_W + 3;

  logic                vld_r  [SQRT_W];
  logic [REM_W-1:0]    rem_r  [SQRT_W];
  logic [SQRT_W-1:0]   root_r [SQRT_W];
  logic [RAD_W-1:0]    rad_r  [SQRT_W];
  sqrt_side_t          side_r [SQRT_W];

  // one result bit per stage, two radicand bits consumed each time
  for (genvar g = 0; g < SQRT_W; g++) begin : g_stage
    logic             vld_in;
    logic [REM_W-1:0] rem_in;
    logic [SQRT_W-1:0] root_in;
    logic [RAD_W-1:0] rad_in;
    sqrt_side_t       side_in;
    logic [REM_W-1:0] rem_sh, trial;

    if (g == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
      if (rem_sh >= trial) begin
        rem_r[g]  <= rem_sh - trial;
        root_r[g] <= {root_in[SQRT_W-2:0], 1'b1};
      end else begin
        rem_r[g]  <= rem_sh;
        root_r[g] <= {root_in[SQRT_W-2:0], 1'b0};
      end
      rad_r[g]  <= rad_in << 2;
      side_r[g] <= side_in;
    end
  end

  assign out_vld  = vld_r[SQRT_W-1];
  assign root     = root_r[SQRT_W-1];
  assign out_side = side_r[SQRT_W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/qrs_div.sv
`default_nettype none
module qrs_div #(
  parameter int unsigned DVD_W = qrs_pkg::MAG_W + qrs_pkg::DEF_FRAC_BITS
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_vld,
  input  wire [qrs_pkg::LANES-1:0][DVD_W-1:0]    dividend,
  input  wire [qrs_pkg::DIVR_W-1:0]              divisor,
  input  qrs_pkg::div_side_t                     in_side,
  output logic                                   out_vld,
  output logic [qrs_pkg::LANES-1:0][DVD_W-1:0]   quot,
  output qrs_pkg::div_side_t                     out_side
);
  import qrs_pkg::*;

  logic                          vld_r  [DVD_W];
  logic [LANES-1:0][DVD_W-1:0]   dvd_r  [DVD_W];
  logic [LANES-1:0][DVD_W-1:0]   quo_r  [DVD_W];
  logic [LANES-1:0][DIVR_W-1:0]  rem_r  [DVD_W];
  logic [DIVR_W-1:0]             dvs_r  [DVD_W];
  div_side_t                     side_r [DVD_W];

  // restoring division, one quotient bit per stage in every lane
  for (genvar g = 0; g < DVD_W; g++) begin : g_stage
    logic                         vld_in;
    logic [LANES-1:0][DVD_W-1:0]  dvd_in, quo_in, quo_nxt;
    logic [LANES-1:0][DIVR_W-1:0] rem_in, rem_nxt;
    logic [DIVR_W-1:0]            dvs_in;
    div_side_t                    side_in;

    if (g == 0) begin : g_first
      assign vld_in  = in_vld;
      assign dvd_in  = dividend;
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign dvs_in  = divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[g-1];
      assign dvd_in  = dvd_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign dvs_in  = dvs_r[g-1];
      assign side_in = side_r[g-1];
    end

    always_comb begin
      logic [DIVR_W:0] rem_sh;
      for (int l = 0; l < LANES; l++) begin
        rem_sh = {rem_in[l], dvd_in[l][DVD_W-1]};
        if (rem_sh >= {1'b0, dvs_in}) begin
          rem_nxt[l] = DIVR_W'(rem_sh - {1'b0, dvs_in});
          quo_nxt[l] = {quo_in[l][DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem_sh[DIVR_W-1:0];
          quo_nxt[l] = {quo_in[l][DVD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
      for (int l = 0; l < LANES; l++) begin
        dvd_r[g][l] <= dvd_in[l] << 1;
      end
      quo_r[g]  <= quo_nxt;
      rem_r[g]  <= rem_nxt;
      dvs_r[g]  <= dvs_in;
      side_r[g] <= side_in;
    end
  end

  assign out_vld  = vld_r[DVD_W-1];
  assign quot     = quo_r[DVD_W-1];
  assign out_side = side_r[DVD_W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/quadratic_root_solver.sv
`default_nettype none
// Quadratic root solver: solves a*x^2 + b*x + c = 0 for signed 16-bit
// coefficients and returns roots in signed fixed point with FRAC_BITS
// fraction bits.
// Input: a transaction is taken on every rising edge with start high and
// busy low; busy is always low, so a new coefficient set may be offered
// every cycle.
// Output: out_valid is high for exactly one cycle with out_root_kind,
// out_root_one, out_root_two and out_imag_part; the receiver must take it.
// Pipeline: a product register and a discriminant register, 17 square-root
// stages (one root bit each), a numerator register, 17 + FRAC_BITS divider
// stages (one quotient bit each), and a sign and saturation register.
// Throughput: one transaction per cycle, set by the fully pipelined
// square-root and divider stages.
// Reset clears the valid bits of every stage; transactions in flight are
// dropped. Results leave in the order their coefficients arrived.
module quadratic_root_solver #(
  parameter int unsigned FRAC_BITS = qrs_pkg::DEF_FRAC_BITS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  signed [qrs_pkg::COEF_W-1:0]  in_coef_a,
  input  wire  signed [qrs_pkg::COEF_W-1:0]  in_coef_b,
  input  wire  signed [qrs_pkg::COEF_W-1:0]  in_coef_c,
  output logic                               out_valid,
  output logic [1:0]                         out_root_kind,
  output logic signed [qrs_pkg::ROOT_W-1:0]  out_root_one,
  output logic signed [qrs_pkg::ROOT_W-1:0]  out_root_two,
  output logic [qrs_pkg::IMAG_W-1:0]         out_imag_part
);
  import qrs_pkg::*;

  localparam int unsigned DVD_W = MAG_W + FRAC_BITS;
  localparam int unsigned XW    = (DVD_W + 1 > ROOT_W + 1) ? DVD_W + 1 : ROOT_W + 1;

  logic                         disc_vld;
  logic [RAD_W-1:0]             disc_rad;
  sqrt_side_t                   disc_side;
  logic                         sq_vld;
  logic [SQRT_W-1:0]            sq_root;
  sqrt_side_t                   sq_side;

  logic signed [MAG_W:0]        nb, s_x, n1, n2, ni;
  logic [MAG_W-1:0]             a_abs;
  logic                         prep_vld_r;
  logic [LANES-1:0][DVD_W-1:0]  dvd_r;
  logic [DIVR_W-1:0]            dvs_r;
  div_side_t                    dside_r;

  logic                         dv_vld;
  logic [LANES-1:0][DVD_W-1:0]  dv_quot;
  div_side_t                    dv_side;

  logic [XW-1:0]                q1_x, q2_x, qi_x;
  logic [XW-1:0]                pos_lim;
  logic [ROOT_W-1:0]            r1_nxt, r2_nxt;
  logic [IMAG_W-1:0]            im_nxt;
  logic                         out_vld_r;
  logic [1:0]                   kind_r;
  logic [ROOT_W-1:0]            r1_r, r2_r;
  logic [IMAG_W-1:0]            im_r;

  assign busy = 1'b0;

  qrs_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .a       (in_coef_a),
    .b       (in_coef_b),
    .c       (in_coef_c),
    .out_vld (disc_vld),
    .rad     (disc_rad),
    .side    (disc_side)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (disc_vld),
    .rad      (disc_rad),
    .in_side  (disc_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // form numerators -b + s, -b - s (both -b unless two real roots) and s (zero unless complex), and the divisor 2|a|
  always_comb begin
    nb    = -(MAG_W+1)'(sq_side.b);
    s_x   = $signed({1'b0, sq_root});
    n1    = (sq_side.kind == KIND_TWO_REAL) ? nb + s_x : nb;
    n2    = (sq_side.kind == KIND_TWO_REAL) ? nb - s_x : nb;
    ni    = (sq_side.kind == KIND_COMPLEX) ? s_x : '0;
    a_abs = sq_side.a[COEF_W-1] ? MAG_W'(-(MAG_W'(sq_side.a))) : MAG_W'(sq_side.a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else begin
      prep_vld_r <= sq_vld;
    end
    dvd_r[0] <= {(n1[MAG_W] ? MAG_W'(-n1) : MAG_W'(n1)), {FRAC_BITS{1'b0}}};
    dvd_r[1] <= {(n2[MAG_W] ? MAG_W'(-n2) : MAG_W'(n2)), {FRAC_BITS{1'b0}}};
    dvd_r[2] <= {MAG_W'(ni), {FRAC_BITS{1'b0}}};
    dvs_r    <= {a_abs[MAG_W-2:0], 1'b0};
    dside_r.kind    <= sq_side.kind;
    dside_r.neg_one <= n1[MAG_W] ^ sq_side.a[COEF_W-1];
    dside_r.neg_two <= n2[MAG_W] ^ sq_side.a[COEF_W-1];
  end

  qrs_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prep_vld_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .in_side  (dside_r),
    .out_vld  (dv_vld),
    .quot     (dv_quot),
    .out_side (dv_side)
  );

  // apply sign and saturate; zero all results for a degenerate equation
  always_comb begin
    pos_lim = (XW'(1) << (ROOT_W-1)) - XW'(1);
    q1_x    = XW'(dv_quot[0]);
    q2_x    = XW'(dv_quot[1]);
    qi_x    = XW'(dv_quot[2]);
    if (dv_side.neg_one) begin
      r1_nxt = (q1_x > pos_lim + XW'(1)) ? {1'b1, {(ROOT_W-1){1'b0}}} : ROOT_W'(-q1_x);
    end else begin
      r1_nxt = (q1_x > pos_lim) ? {1'b0, {(ROOT_W-1){1'b1}}} : ROOT_W'(q1_x);
    end
    if (dv_side.neg_two) begin
      r2_nxt = (q2_x > pos_lim + XW'(1)) ? {1'b1, {(ROOT_W-1){1'b0}}} : ROOT_W'(-q2_x);
    end else begin
      r2_nxt = (q2_x > pos_lim) ? {1'b0, {(ROOT_W-1){1'b1}}} : ROOT_W'(q2_x);
    end
    im_nxt = (qi_x > pos_lim) ? {IMAG_W{1'b1}} : IMAG_W'(qi_x);
    if (dv_side.kind == KIND_DEGEN) begin
      r1_nxt = '0;
      r2_nxt = '0;
      im_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
    kind_r <= dv_side.kind;
    r1_r   <= r1_nxt;
    r2_r   <= r2_nxt;
    im_r   <= im_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_root_kind = kind_r;
  assign out_root_one  = $signed(r1_r);
  assign out_root_two  = $signed(r2_r);
  assign out_imag_part = im_r;

endmodule
`default_nettype wire
